### rtl/pru_pkg.sv
// package: shared constants, types and helpers for the premultiplied rgba16 to srgb8 core
`default_nettype none
package pru_pkg;

  localparam int BUCKET_SHIFT = 4;
  localparam int BUCKET_AW    = 12;
  localparam int FWD_AW       = 8;
  localparam int DIV_STEPS    = 16;
  // lane latency: operand stage, division steps, rounding stage
  localparam int LANE_LAT     = DIV_STEPS + 2;

  localparam logic [1:0] CMD_LOAD_FWD = 2'd0;
  localparam logic [1:0] CMD_LOAD_BKT = 2'd1;
  localparam logic [1:0] CMD_CONVERT  = 2'd2;

  localparam logic [15:0] ALPHA_FULL = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_SAT  = 2'd1,
    MODE_PASS = 2'd2,
    MODE_DIV  = 2'd3
  } lane_mode_e;

  // pipeline side information carried next to the colour lanes
  typedef struct packed {
    logic        vld;
    logic [1:0]  cmd;
    logic [11:0] idx;
    logic [15:0] val;
    logic [15:0] alpha;
  } meta_t;

endpackage
`default_nettype wire

### rtl/pru_unpremul.sv
// un-premultiplying lane: pipelined restoring divider with round-half-even
`default_nettype none
module pru_unpremul import pru_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] v_i,
  input  wire logic [15:0] a_i,
  output logic      [15:0] res_o
);

  logic [15:0] rem_q  [0:DIV_STEPS];
  logic [15:0] quo_q  [0:DIV_STEPS];
  logic [15:0] low_q  [0:DIV_STEPS];
  logic [15:0] div_q  [0:DIV_STEPS];
  logic [15:0] v_q    [0:DIV_STEPS];
  lane_mode_e  mode_q [0:DIV_STEPS];
  logic [15:0] res_q;

  lane_mode_e  mode_d;
  logic [31:0] num_d;

  // operand classification and numerator v*65535
  always_comb begin
    num_d = {v_i, 16'd0} - {16'd0, v_i};
    if (a_i == 16'd0 || v_i == 16'd0) begin
      mode_d = MODE_ZERO;
    end else if (v_i >= a_i) begin
      mode_d = MODE_SAT;
    end else if (a_i == ALPHA_FULL) begin
      mode_d = MODE_PASS;
    end else begin
      mode_d = MODE_DIV;
    end
  end

  // one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_d[31:16];
      quo_q[0]  <= '0;
      low_q[0]  <= num_d[15:0];
      div_q[0]  <= a_i;
      v_q[0]    <= v_i;
      mode_q[0] <= mode_d;
      for (int k = 0; k < DIV_STEPS; k++) begin
        logic [16:0] t;
        t = {rem_q[k], low_q[k][15]};
        if (t >= {1'b0, div_q[k]}) begin
          rem_q[k+1] <= 16'(t - {1'b0, div_q[k]});
          quo_q[k+1] <= {quo_q[k][14:0], 1'b1};
        end else begin
          rem_q[k+1] <= t[15:0];
          quo_q[k+1] <= {quo_q[k][14:0], 1'b0};
        end
        low_q[k+1]  <= {low_q[k][14:0], 1'b0};
        div_q[k+1]  <= div_q[k];
        v_q[k+1]    <= v_q[k];
        mode_q[k+1] <= mode_q[k];
      end
    end
  end

  // rounding and special cases
  logic [16:0] twice;
  logic [16:0] inc;
  logic        up;
  always_comb begin
    twice = {rem_q[DIV_STEPS], 1'b0};
    up    = (twice > {1'b0, div_q[DIV_STEPS]}) ||
            (twice == {1'b0, div_q[DIV_STEPS]} && quo_q[DIV_STEPS][0]);
    inc   = {1'b0, quo_q[DIV_STEPS]} + {16'd0, up};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (mode_q[DIV_STEPS])
        MODE_ZERO: res_q <= '0;
        MODE_SAT:  res_q <= 16'hFFFF;
        MODE_PASS: res_q <= v_q[DIV_STEPS];
        MODE_DIV:  res_q <= inc[16] ? 16'hFFFF : inc[15:0];
        default:   res_q <= '0;
      endcase
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

### rtl/premul_rgba16_to_srgb8_core.sv
// top level: premultiplied linear rgba16 to straight srgb8 converter with loadable tables
//
//  channel | signals                                  | direction
//  in      | in_valid_i, in_stall_o, cmd_i ... alpha_in_i | word in
//  out     | out_valid_o, out_stall_i, red_out_o ... alpha_out_o | word out
//
// one word per cycle while the output is not stalled; a pixel passes through the
// sixteen-step divider pipeline, the two table read stages and the output register
// table loads travel the same pipeline and write where the tables are read,
// so pixel and load order is kept
// reset clears only the valid bits; tables hold nothing until loaded
// a stalled valid output freezes the whole pipeline
`default_nettype none
module premul_rgba16_to_srgb8_core import pru_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [11:0] table_index_i,
  input  wire logic [15:0] table_value_i,
  input  wire logic [15:0] red_in_i,
  input  wire logic [15:0] green_in_i,
  input  wire logic [15:0] blue_in_i,
  input  wire logic [15:0] alpha_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       alpha_out_o
);

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // colour lanes
  logic [15:0] lin [0:2];
  logic [15:0] vin [0:2];
  assign vin[0] = red_in_i;
  assign vin[1] = green_in_i;
  assign vin[2] = blue_in_i;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    pru_unpremul u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (vin[c]),
      .a_i   (alpha_in_i),
      .res_o (lin[c])
    );
  end

  // side information alongside the lanes
  meta_t meta_q [0:LANE_LAT-1];
  meta_t meta_in;
  always_comb begin
    meta_in.vld   = in_valid_i;
    meta_in.cmd   = cmd_i;
    meta_in.idx   = table_index_i;
    meta_in.val   = table_value_i;
    meta_in.alpha = alpha_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANE_LAT; k++) meta_q[k].vld <= 1'b0;
    end else if (en) begin
      meta_q[0] <= meta_in;
      for (int k = 1; k < LANE_LAT; k++) meta_q[k] <= meta_q[k-1];
    end
  end

  meta_t mt;
  assign mt = meta_q[LANE_LAT-1];

  // bucket tables, one copy per colour, written and read at this stage
  logic [7:0]  bkt_mem0 [0:(1<<BUCKET_AW)-1];
  logic [7:0]  bkt_mem1 [0:(1<<BUCKET_AW)-1];
  logic [7:0]  bkt_mem2 [0:(1<<BUCKET_AW)-1];
  logic [BUCKET_AW-1:0] lin_sh [0:2];
  logic        bkt_we;
  assign bkt_we = en && mt.vld && (mt.cmd == CMD_LOAD_BKT);
  for (genvar c = 0; c < 3; c++) begin : g_sh
    assign lin_sh[c] = BUCKET_AW'(lin[c] >> BUCKET_SHIFT);
  end

  logic [7:0]  code_q [0:2];
  logic [15:0] lin_b_q [0:2];
  meta_t       mb_q;

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bkt_mem0[mt.idx] <= mt.val[7:0];
      bkt_mem1[mt.idx] <= mt.val[7:0];
      bkt_mem2[mt.idx] <= mt.val[7:0];
    end
    if (en) begin
      code_q[0] <= bkt_mem0[lin_sh[0]];
      code_q[1] <= bkt_mem1[lin_sh[1]];
      code_q[2] <= bkt_mem2[lin_sh[2]];
      for (int c = 0; c < 3; c++) lin_b_q[c] <= lin[c];
    end
  end

  // forward tables, one copy per colour, two reads each
  logic [15:0] fwd_mem0 [0:(1<<FWD_AW)-1];
  logic [15:0] fwd_mem1 [0:(1<<FWD_AW)-1];
  logic [15:0] fwd_mem2 [0:(1<<FWD_AW)-1];
  logic        fwd_we;
  logic [7:0]  code_n [0:2];
  assign fwd_we = en && mb_q.vld && (mb_q.cmd == CMD_LOAD_FWD) &&
                  (mb_q.idx[11:FWD_AW] == '0);
  for (genvar c = 0; c < 3; c++) begin : g_nx
    assign code_n[c] = code_q[c] + 8'd1;
  end

  logic [15:0] f0_q [0:2];
  logic [15:0] f1_q [0:2];
  logic [7:0]  code_f_q [0:2];
  logic [15:0] lin_f_q [0:2];
  meta_t       mf_q;

  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem0[mb_q.idx[FWD_AW-1:0]] <= mb_q.val;
      fwd_mem1[mb_q.idx[FWD_AW-1:0]] <= mb_q.val;
      fwd_mem2[mb_q.idx[FWD_AW-1:0]] <= mb_q.val;
    end
    if (en) begin
      f0_q[0] <= fwd_mem0[code_q[0]];
      f1_q[0] <= fwd_mem0[code_n[0]];
      f0_q[1] <= fwd_mem1[code_q[1]];
      f1_q[1] <= fwd_mem1[code_n[1]];
      f0_q[2] <= fwd_mem2[code_q[2]];
      f1_q[2] <= fwd_mem2[code_n[2]];
      for (int c = 0; c < 3; c++) begin
        code_f_q[c] <= code_q[c];
        lin_f_q[c]  <= lin_b_q[c];
      end
    end
  end

  // side information through the two table stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mb_q.vld <= 1'b0;
      mf_q.vld <= 1'b0;
    end else if (en) begin
      mb_q <= mt;
      mf_q <= mb_q;
    end
  end

  function automatic logic [7:0] code_n_f(input logic [7:0] x);
    code_n_f = x + 8'd1;
  endfunction

  // midpoint test, ties to the even code
  logic [7:0] code_o [0:2];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [16:0] mid;
      logic [16:0] twice;
      mid   = {1'b0, f0_q[c]} + {1'b0, f1_q[c]};
      twice = {lin_f_q[c], 1'b0};
      code_o[c] = code_f_q[c];
      if (code_f_q[c] != 8'hFF &&
          (twice > mid || (twice == mid && code_f_q[c][0]))) begin
        code_o[c] = code_n_f(code_f_q[c]);
      end
    end
  end

  // alpha divided by 257, remainder is never exactly half
  logic [7:0] a8;
  always_comb begin
    logic [8:0] q0;
    logic [9:0] r0;
    logic [8:0] q1;
    q0 = {1'b0, mf_q.alpha[15:8]};
    r0 = {2'b0, mf_q.alpha[7:0]} - {1'b0, q0};
    if (r0[9]) begin
      q0 = q0 - 9'd1;
      r0 = r0 + 10'd257;
    end
    q1 = q0 + ((r0 >= 10'd129) ? 9'd1 : 9'd0);
    a8 = q1[8] ? 8'hFF : q1[7:0];
  end

  // output register
  logic conv_f;
  assign conv_f = mf_q.vld && (mf_q.cmd == CMD_CONVERT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= conv_f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (mf_q.alpha == 16'd0) begin
        red_out_o   <= '0;
        green_out_o <= '0;
        blue_out_o  <= '0;
      end else begin
        red_out_o   <= code_o[0];
        green_out_o <= code_o[1];
        blue_out_o  <= code_o[2];
      end
      alpha_out_o <= a8;
    end
  end

  // checks
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(mf_q.vld) && $stable(mb_q.vld))
    else $error("pipeline moved while stalled");
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_out_o))
    else $error("pending word lost");
  a_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bkt_we && fwd_we && (mt.idx == mb_q.idx) && (mt.cmd == mb_q.cmd)))
    else $error("bucket and forward load collide");

endmodule
`default_nettype wire

### dv/tb.sv
// testbench for the premultiplied rgba16 to srgb8 core: directed table, random words, predictor
`default_nettype none
module tb;
  import pru_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         WD_LIMIT   = 5000;
  localparam int         N_WORDS    = 900;
  localparam int         LONG_HOLD  = 80;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] idx;
    logic [15:0] val;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        typed;
    pixel_t      want;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_LOAD_FWD;
  logic [11:0] table_index_i = '0;
  logic [15:0] table_value_i = '0;
  logic [15:0] red_in_i = '0;
  logic [15:0] green_in_i = '0;
  logic [15:0] blue_in_i = '0;
  logic [15:0] alpha_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic [7:0]  alpha_out_o;

  // side info travelling with the driven word
  logic        word_typed = 1'b0;
  pixel_t      word_want = '0;

  logic        idling_on = 1'b1;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;

  logic [15:0] fwd_lut [256];
  logic [7:0]  bkt_lut [4096];
  pixel_t      pixel_q [$];
  int          n_mismatch = 0;
  int          n_pixels = 0;
  int          n_words = 0;
  int          idle_cycles = 0;

  // sender side view of which table entries are defined
  logic [15:0] curve [256];
  logic        bkt_set [4096];
  logic [7:0]  bkt_shd [4096];
  logic        fwd_set [256];
  int          n_sent = 0;

  premul_rgba16_to_srgb8_core u_top (.*);

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // colour divided by alpha, scaled to 65535, ties to even
  function automatic logic [31:0] straighten(logic [31:0] v, logic [31:0] a);
    logic [31:0] q, r, twice;
    if (a == 0 || v == 0) return 0;
    if (v >= a) return 65535;
    if (a == 65535) return v;
    q = (v * 65535) / a;
    r = (v * 65535) % a;
    twice = r * 2;
    if (twice > a || (twice == a && q[0])) q++;
    if (q > 65535) q = 65535;
    return q;
  endfunction

  // bucket lookup then one midpoint test against the forward table
  function automatic logic [7:0] encode_srgb(logic [31:0] v);
    logic [31:0] code, mid;
    code = bkt_lut[(v >> BUCKET_SHIFT) & 32'hFFF];
    if (code < 255) begin
      mid = fwd_lut[code] + fwd_lut[code + 1];
      if (v * 2 > mid || (v * 2 == mid && code[0])) code++;
    end
    return code[7:0];
  endfunction

  function automatic logic [7:0] alpha_to_8(logic [31:0] a);
    logic [31:0] q, r;
    q = a / 257;
    r = a % 257;
    if (r * 2 > 257 || (r * 2 == 257 && q[0])) q++;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic pixel_t convert_pixel(logic [15:0] r, logic [15:0] g,
                                           logic [15:0] b, logic [15:0] a);
    pixel_t p;
    if (a == 0) p = '0;
    else if (a == ALPHA_FULL) begin
      p = '{encode_srgb(r), encode_srgb(g), encode_srgb(b), 8'd255};
    end else begin
      p.red   = encode_srgb(straighten(r, a));
      p.green = encode_srgb(straighten(g, a));
      p.blue  = encode_srgb(straighten(b, a));
      p.alpha = alpha_to_8(a);
    end
    return p;
  endfunction

  // predictor on accepted input words, checker on accepted output words
  always @(posedge clk_i) begin
    pixel_t got, exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{red_out_o, green_out_o, blue_out_o, alpha_out_o};
      if (pixel_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected pixel %h", got);
      end else begin
        exp_px = pixel_q.pop_front();
        n_pixels++;
        if (got !== exp_px) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("pixel mismatch: exp r%h g%h b%h a%h got r%h g%h b%h a%h",
                     exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                     got.red, got.green, got.blue, got.alpha);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      n_words++;
      case (cmd_i)
        CMD_LOAD_FWD: if (table_index_i < 256) fwd_lut[table_index_i[7:0]] = table_value_i;
        CMD_LOAD_BKT: bkt_lut[table_index_i] = table_value_i[7:0];
        CMD_CONVERT: begin
          if (word_typed) pixel_q.push_back(word_want);
          else pixel_q.push_back(convert_pixel(red_in_i, green_in_i, blue_in_i, alpha_in_i));
        end
        default: ;
      endcase
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts and one long hold-off
  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_stall_i <= 1'b1;
        for (k = 0; k < LONG_HOLD; k++) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic offer(input stim_t s);
    in_valid_i    <= 1'b1;
    cmd_i         <= s.cmd;
    table_index_i <= s.idx;
    table_value_i <= s.val;
    red_in_i      <= s.red;
    green_in_i    <= s.green;
    blue_in_i     <= s.blue;
    alpha_in_i    <= s.alpha;
    word_typed    <= s.typed;
    word_want     <= s.want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic maybe_gap();
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  function automatic stim_t load_word(logic [1:0] c, logic [11:0] i, logic [15:0] v);
    stim_t s;
    s = '0;
    s.cmd = c; s.idx = i; s.val = v;
    return s;
  endfunction

  function automatic stim_t pixel_word(logic [15:0] r, logic [15:0] g,
                                       logic [15:0] b, logic [15:0] a);
    stim_t s;
    s = '0;
    s.cmd = CMD_CONVERT; s.red = r; s.green = g; s.blue = b; s.alpha = a;
    return s;
  endfunction

  function automatic real srgb_to_linear(real s);
    if (s <= 0.04045) return s / 12.92;
    return $pow((s + 0.055) / 1.055, 2.4);
  endfunction

  // send one word and note which table entries it defines
  task automatic send(input stim_t s);
    if (s.cmd == CMD_LOAD_FWD && s.idx < 12'd256) fwd_set[s.idx[7:0]] = 1'b1;
    if (s.cmd == CMD_LOAD_BKT) begin
      bkt_set[s.idx] = 1'b1;
      bkt_shd[s.idx] = s.val[7:0];
    end
    n_sent++;
    offer(s);
    maybe_gap();
  endtask

  // load the bucket and forward entries a linear value reads, where still undefined
  task automatic need_lin(input logic [31:0] v);
    logic [11:0] bi;
    int          cd;
    bi = 12'(v >> BUCKET_SHIFT);
    if (!bkt_set[bi]) begin
      cd = 0;
      while (cd < 255 && int'(curve[cd + 1]) <= (int'(bi) << BUCKET_SHIFT)) cd++;
      send(load_word(CMD_LOAD_BKT, bi, 16'(cd)));
    end
    cd = int'(bkt_shd[bi]);
    for (int k = cd; k <= cd + 1 && k < 256; k++) begin
      if (!fwd_set[k]) send(load_word(CMD_LOAD_FWD, 12'(k), curve[k]));
    end
  endtask

  // issue a word, first loading whatever a pixel reads from the tables
  task automatic issue(input stim_t s);
    if (s.cmd == CMD_CONVERT && s.alpha != 16'd0) begin
      if (s.alpha == ALPHA_FULL) begin
        need_lin({16'd0, s.red});
        need_lin({16'd0, s.green});
        need_lin({16'd0, s.blue});
      end else begin
        need_lin(straighten({16'd0, s.red}, {16'd0, s.alpha}));
        need_lin(straighten({16'd0, s.green}, {16'd0, s.alpha}));
        need_lin(straighten({16'd0, s.blue}, {16'd0, s.alpha}));
      end
    end
    send(s);
  endtask

  // stimulus
  initial begin
    stim_t       rows [$];
    stim_t       s;
    logic [15:0] a16;
    logic        paused;
    int          c, n;
    real         x;

    paused = 1'b0;

    // directed words that read no table entry
    s = pixel_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    s.typed = 1'b1; s.want = '0;                       // zero alpha
    rows.push_back(s);
    s = pixel_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    s.typed = 1'b1; s.want = '0;
    rows.push_back(s);
    s = pixel_word(16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFF);
    s.cmd = CMD_UNUSED;                                // unused command
    rows.push_back(s);
    rows.push_back(load_word(CMD_LOAD_FWD, 12'd300, 16'h1234));  // index too large
    rows.push_back(load_word(CMD_LOAD_FWD, 12'hFFF, 16'hFFFF));

    // gamma curve used for every table entry loaded on demand
    for (c = 0; c < 256; c++) begin
      x = srgb_to_linear(c / 255.0) * 65535.0 + 0.5;
      curve[c] = 16'($rtoi(x));
      fwd_set[c] = 1'b0;
    end
    for (c = 0; c < 4096; c++) begin
      bkt_set[c] = 1'b0;
      bkt_shd[c] = '0;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) issue(rows[i]);
    rows.delete();

    // directed words, table entries they read loaded just before
    rows.push_back(pixel_word(16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF));  // full alpha
    rows.push_back(pixel_word(16'h0001, 16'h0100, 16'h1000, 16'hFFFF));
    rows.push_back(pixel_word(16'h0000, 16'h0001, 16'hFFFF, 16'h0001));  // tiny alpha
    rows.push_back(pixel_word(16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFE));
    rows.push_back(pixel_word(16'h0040, 16'h0080, 16'h00FF, 16'h0080));  // saturate at alpha
    rows.push_back(pixel_word(16'h0010, 16'h0020, 16'h0030, 16'h0081));
    rows.push_back(pixel_word(16'h0100, 16'h00C0, 16'h0001, 16'h0181));
    rows.push_back(pixel_word(16'h3333, 16'h1111, 16'h2222, 16'h8000));
    rows.push_back(load_word(CMD_LOAD_BKT, 12'h000, 16'hFF03));  // wide bucket value
    rows.push_back(pixel_word(16'h0005, 16'h000F, 16'h0000, 16'hFFFF));
    rows.push_back(load_word(CMD_LOAD_FWD, 12'd255, 16'hFFFF));  // all 16 bits kept
    rows.push_back(pixel_word(16'hFFFF, 16'hFFF0, 16'hFF00, 16'hFFFF));
    rows.push_back(load_word(CMD_LOAD_BKT, 12'hFFF, 16'h00FF));
    rows.push_back(pixel_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    foreach (rows[i]) issue(rows[i]);

    // random words: mostly pixels, some table rewrites
    while (n_sent < N_WORDS) begin
      if (n_sent >= N_WORDS - 150) idling_on <= 1'b0;
      if (n_sent >= 300) long_hold_req <= 1'b1;
      if (n_sent >= 600 && !paused) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        wait (pixel_q.size() == 0);
        @(posedge clk_i);
      end
      c = $urandom_range(0, 19);
      if (c == 0) begin
        s = load_word(CMD_LOAD_FWD, 12'($urandom_range(0, 4095)),
                      16'($urandom_range(0, 65535)));
      end else if (c == 1) begin
        s = load_word(CMD_LOAD_BKT, 12'($urandom_range(0, 4095)),
                      16'($urandom_range(0, 65535)));
      end else if (c == 2) begin
        s = pixel_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        s.cmd = CMD_UNUSED;
        s.idx = 12'($urandom); s.val = 16'($urandom);
      end else begin
        s = pixel_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        case ($urandom_range(0, 5))
          0: s.alpha = 16'hFFFF;
          1: s.alpha = 16'h0000;
          2: begin
            a16 = 16'($urandom_range(1, 65534));
            s.alpha = a16;
            s.red = 16'($urandom_range(0, a16));
            s.green = 16'($urandom_range(0, a16));
            s.blue = 16'($urandom_range(0, a16));
          end
          default: ;
        endcase
      end
      issue(s);
    end
    in_valid_i <= 1'b0;

    // drain
    n = 0;
    while (pixel_q.size() != 0 && n < WD_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (LANE_LAT + 10) @(posedge clk_i);

    $display("covered %0d input words and %0d checked pixels, with on-demand and random",
             n_words, n_pixels);
    $display("table loads, zero, full and partial alpha, and long output hold-off");
    if (n_mismatch == 0 && pixel_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d pixels missing", n_mismatch, pixel_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
